// ===== src/fit_policy_block_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// fit policy block allocator assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// property holds at every edge outside reset
`define FPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// types and constants shared by the fit policy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int unsigned BlockIdxW = 4;
  localparam int unsigned AmountW   = 16;
  localparam int unsigned MaxSizeW  = 32;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned FitModeW  = 2;
  localparam int unsigned BlkCntW   = 5;

  localparam logic [CfgIdxW-1:0] CfgFitMode    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockCount = 1'b1;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdAlloc = 1'b1
  } cmd_e;

  typedef enum logic [FitModeW-1:0] {
    FitFirst = 2'd0,
    FitBest  = 2'd1,
    FitWorst = 2'd2
  } fit_mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StResp
  } state_e;

  // control from the sequencer to the selection unit
  typedef struct packed {
    logic clear;
    logic sample;
    logic first;
  } sel_ctrl_t;

endpackage

`default_nettype wire

// ===== src/fpba_if.sv =====
// ----------------------------------------------------------------------------
// fpba channel interfaces
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [fpba_pkg::BlockIdxW-1:0]      block_index;
  logic [fpba_pkg::AmountW-1:0]        amount;

  modport source (output valid, cmd, block_index, amount, input ready);
  modport sink   (input valid, cmd, block_index, amount, output ready);
endinterface

interface fpba_out_if;
  logic                                valid;
  logic                                ready;
  logic                                granted;
  logic [fpba_pkg::BlockIdxW-1:0]      chosen_block;
  logic [fpba_pkg::AmountW-1:0]        space_left;

  modport source (output valid, granted, chosen_block, space_left, input ready);
  modport sink   (input valid, granted, chosen_block, space_left, output ready);
endinterface

`default_nettype wire

// ===== src/fpba_mem.sv =====
// ----------------------------------------------------------------------------
// fpba_mem
// free space table, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/fpba_sel.sv =====
// ----------------------------------------------------------------------------
// fpba_sel
// running candidate tracker for first, best and worst fit
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_sel #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned SizeW = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fpba_pkg::sel_ctrl_t               ctrl_i,
  input  wire logic [fpba_pkg::FitModeW-1:0]     mode_i,
  input  wire logic [IdxW-1:0]                   idx_i,
  input  wire logic [SizeW-1:0]                  val_i,
  input  wire logic [SizeW-1:0]                  need_i,
  output logic                                   grant_o,
  output logic      [IdxW-1:0]                   best_idx_o,
  output logic      [SizeW-1:0]                  remain_o
);

  logic             found_q;
  logic [IdxW-1:0]  best_idx_q;
  logic [SizeW-1:0] best_val_q;
  logic             fits;
  logic             take;

  assign fits = val_i >= need_i;

  always_comb begin
    case (mode_i)
      fpba_pkg::FitFirst: take = fits && !found_q;
      fpba_pkg::FitBest:  take = fits && (!found_q || (val_i < best_val_q));
      fpba_pkg::FitWorst: take = ctrl_i.first || (val_i > best_val_q);
      default:            take = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctrl_i.sample && take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample && take) begin
      best_idx_q <= idx_i;
      best_val_q <= val_i;
    end
  end

  // worst fit keeps the largest block and grants only if it fits
  always_comb begin
    case (mode_i)
      fpba_pkg::FitFirst: grant_o = found_q;
      fpba_pkg::FitBest:  grant_o = found_q;
      fpba_pkg::FitWorst: grant_o = found_q && (best_val_q >= need_i);
      default:            grant_o = 1'b0;
    endcase
  end

  assign best_idx_o = best_idx_q;
  assign remain_o   = best_val_q - need_i;

endmodule

`default_nettype wire

// ===== src/fit_policy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// load beat: result registered in the output reg, or held pending while that reg is full
// request beat: one table read a cycle through the single read port, then a
//   write-back state; the scan length is block_count with zero read as one and
//   large counts clamped to NUM_BLOCKS
// one command in flight; the next is taken while a result waits in the output reg
// reset clears control and config (fit_mode 0, block_count 1); table is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

`include "fit_policy_block_allocator_unit_macros.svh"

module fit_policy_block_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fpba_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [fpba_pkg::CfgDataW-1:0]     cfg_data_i,
  fpba_in_if.sink                                req,
  fpba_out_if.source                             rsp
);

  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(NUM_BLOCKS + 1);

  // config registers
  logic [fpba_pkg::FitModeW-1:0] fit_mode_q;
  logic [fpba_pkg::BlkCntW-1:0]  block_count_q;

  // sequencer state
  fpba_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  iss_q;       // next table index to read
  logic [CntW-1:0]  scan_n_q;    // blocks to scan for this request
  logic [IdxW-1:0]  chk_q;       // index of the word arriving from the table
  logic             rvld_q;
  logic [SIZE_BITS-1:0] need_q;

  // pending result when the output reg is still full
  logic                             pend_grant_q;
  logic [fpba_pkg::BlockIdxW-1:0]   pend_idx_q;
  logic [fpba_pkg::AmountW-1:0]     pend_space_q;

  // output register
  logic                             out_vld_q;
  logic                             out_grant_q;
  logic [fpba_pkg::BlockIdxW-1:0]   out_idx_q;
  logic [fpba_pkg::AmountW-1:0]     out_space_q;

  // table port
  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_waddr, mem_raddr;
  logic [SIZE_BITS-1:0] mem_wdata, mem_rdata;

  // selection unit
  fpba_pkg::sel_ctrl_t  sel_ctrl;
  logic                 sel_grant;
  logic [IdxW-1:0]      sel_idx;
  logic [SIZE_BITS-1:0] sel_remain;

  // beat decode and width fitting
  logic                              acc;
  logic                              is_load;
  logic                              in_range;
  logic [fpba_pkg::MaxSizeW-1:0]     amt_ext;
  logic [SIZE_BITS-1:0]              amt;
  logic [fpba_pkg::MaxSizeW-1:0]     amt_back;
  logic [fpba_pkg::MaxSizeW-1:0]     remain_ext;
  logic [7:0]                        load_idx_ext;
  logic [7:0]                        best_idx_ext;
  logic [8:0]                        bc_ext;
  logic [8:0]                        scan_n_ext;
  logic                              scan_last;

  // result mux
  logic                              res_vld;
  logic                              res_grant;
  logic [fpba_pkg::BlockIdxW-1:0]    res_idx;
  logic [fpba_pkg::AmountW-1:0]      res_space;
  logic                              out_free;
  logic                              out_load;

  assign acc      = req.valid && req.ready;
  assign is_load  = (req.cmd == fpba_pkg::CmdLoad);
  assign in_range = 9'(req.block_index) < 9'(NUM_BLOCKS);

  // amount is cut or zero-extended to the table width
  assign amt_ext    = fpba_pkg::MaxSizeW'(req.amount);
  assign amt        = amt_ext[SIZE_BITS-1:0];
  assign amt_back   = fpba_pkg::MaxSizeW'(amt);
  assign remain_ext = fpba_pkg::MaxSizeW'(sel_remain);

  assign load_idx_ext = 8'(req.block_index);
  assign best_idx_ext = 8'(sel_idx);

  // scan length: zero reads as one, large counts saturate at the table depth
  assign bc_ext = 9'(block_count_q);
  always_comb begin
    if (bc_ext == 9'd0) begin
      scan_n_ext = 9'd1;
    end else if (bc_ext > 9'(NUM_BLOCKS)) begin
      scan_n_ext = 9'(NUM_BLOCKS);
    end else begin
      scan_n_ext = bc_ext;
    end
  end

  assign scan_last = rvld_q && ((CntW'(chk_q) + CntW'(1)) == scan_n_q);

  assign out_free = !out_vld_q || rsp.ready;
  assign out_load = res_vld && out_free;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= fpba_pkg::FitFirst;
      block_count_q <= fpba_pkg::BlkCntW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fpba_pkg::CfgFitMode) begin
        fit_mode_q <= cfg_data_i[fpba_pkg::FitModeW-1:0];
      end else begin
        block_count_q <= cfg_data_i;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpba_pkg::StIdle: begin
        if (acc && !is_load) begin
          state_d = fpba_pkg::StScan;
        end else if (acc && !out_free) begin
          state_d = fpba_pkg::StResp;
        end
      end
      fpba_pkg::StScan: begin
        if (scan_last) begin
          state_d = fpba_pkg::StWrite;
        end
      end
      fpba_pkg::StWrite: begin
        state_d = out_free ? fpba_pkg::StIdle : fpba_pkg::StResp;
      end
      fpba_pkg::StResp: begin
        if (out_free) begin
          state_d = fpba_pkg::StIdle;
        end
      end
      default: state_d = fpba_pkg::StIdle;
    endcase
  end

  // sequencer outputs: table port, selection control and the result beat
  always_comb begin
    req.ready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    sel_ctrl       = '0;
    res_vld        = 1'b0;
    res_grant      = 1'b0;
    res_idx        = '0;
    res_space      = '0;
    case (state_q)
      fpba_pkg::StIdle: begin
        // ready is high here, so a valid beat is taken
        req.ready = 1'b1;
        if (req.valid && is_load) begin
          // an in-range load goes straight into the table, result right away
          mem_we    = in_range;
          mem_waddr = load_idx_ext[IdxW-1:0];
          mem_wdata = amt;
          res_vld   = 1'b1;
          res_grant = in_range;
          res_idx   = in_range ? req.block_index : '0;
          res_space = in_range ? amt_back[fpba_pkg::AmountW-1:0] : '0;
        end else if (req.valid) begin
          // request: fetch block 0 and reset the candidate
          mem_re         = 1'b1;
          mem_raddr      = '0;
          sel_ctrl.clear = 1'b1;
        end
      end
      fpba_pkg::StScan: begin
        mem_re          = iss_q < scan_n_q;
        mem_raddr       = iss_q[IdxW-1:0];
        sel_ctrl.sample = rvld_q;
        sel_ctrl.first  = (chk_q == '0);
      end
      fpba_pkg::StWrite: begin
        // write back the reduced block, no other table access this cycle
        mem_we    = sel_grant;
        mem_waddr = sel_idx;
        mem_wdata = sel_remain;
        res_vld   = 1'b1;
        res_grant = sel_grant;
        res_idx   = sel_grant ? best_idx_ext[fpba_pkg::BlockIdxW-1:0] : '0;
        res_space = sel_grant ? remain_ext[fpba_pkg::AmountW-1:0] : '0;
      end
      fpba_pkg::StResp: begin
        res_vld   = 1'b1;
        res_grant = pend_grant_q;
        res_idx   = pend_idx_q;
        res_space = pend_space_q;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fpba_pkg::StIdle;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= mem_re;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // scan counters and request operands
  always_ff @(posedge clk_i) begin
    chk_q <= mem_raddr;
    if (acc && !is_load) begin
      iss_q    <= CntW'(1);
      scan_n_q <= scan_n_ext[CntW-1:0];
      need_q   <= amt;
    end else if ((state_q == fpba_pkg::StScan) && mem_re) begin
      iss_q <= iss_q + CntW'(1);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_vld && !out_free) begin
      pend_grant_q <= res_grant;
      pend_idx_q   <= res_idx;
      pend_space_q <= res_space;
    end
    if (out_load) begin
      out_grant_q <= res_grant;
      out_idx_q   <= res_idx;
      out_space_q <= res_space;
    end
  end

  assign rsp.valid        = out_vld_q;
  assign rsp.granted      = out_grant_q;
  assign rsp.chosen_block = out_idx_q;
  assign rsp.space_left   = out_space_q;

  fpba_mem #(
    .Depth (NUM_BLOCKS),
    .AddrW (IdxW),
    .DataW (SIZE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fpba_sel #(
    .IdxW  (IdxW),
    .SizeW (SIZE_BITS)
  ) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sel_ctrl),
    .mode_i     (fit_mode_q),
    .idx_i      (chk_q),
    .val_i      (mem_rdata),
    .need_i     (need_q),
    .grant_o    (sel_grant),
    .best_idx_o (sel_idx),
    .remain_o   (sel_remain)
  );

  // read and write never share a cycle, so no forwarding path is needed
  `FPBA_ASSERT(a_no_rw_overlap, !(mem_we && mem_re), "table read and write in one cycle")
  `FPBA_ASSERT(a_iss_bound, (state_q == fpba_pkg::StScan) |-> (iss_q <= scan_n_q), "scan overrun")
  `FPBA_ASSERT(a_chk_bound, rvld_q |-> (CntW'(chk_q) < scan_n_q), "read beyond scan length")
  `FPBA_ASSERT_NEXT(a_write_after_last, (state_q == fpba_pkg::StScan) && scan_last, state_q == fpba_pkg::StWrite, "no write-back after last block")

endmodule

`default_nettype wire
